### src/ikd_pkg.sv
// Shared types and constants for the integrator key debouncer.
package ikd_pkg;

    localparam int DELAY_W      = 14;
    localparam int TICK_W       = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 8;
    localparam int COUNT_MAX_DEFAULT = 16383;

    localparam logic [DELAY_W-1:0] PRESS_DELAY_RST   = DELAY_W'(5);
    localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = DELAY_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_DELAY   = 2'd0,
        REG_RELEASE_DELAY = 2'd1,
        REG_EAGER_MODE    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DELAY_W-1:0] press_delay_ms;
        logic [DELAY_W-1:0] release_delay_ms;
        logic               eager_mode;
    } ikd_cfg_t;

    typedef struct packed {
        logic still_active;
        logic state_changed;
        logic debounced_pressed;
    } ikd_result_t;

endpackage

### src/ikd_cfg_regs.sv
// Configuration register file for the debouncer delays and mode.
module ikd_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [ikd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ikd_pkg::CFG_DATA_W-1:0] cfg_data,
    output ikd_pkg::ikd_cfg_t             cfg
);
    import ikd_pkg::*;

    ikd_cfg_t cfg_reg;
    ikd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PRESS_DELAY:   cfg_next.press_delay_ms   = cfg_data[DELAY_W-1:0];
                REG_RELEASE_DELAY: cfg_next.release_delay_ms = cfg_data[DELAY_W-1:0];
                REG_EAGER_MODE:    cfg_next.eager_mode       = cfg_data[0];
                default:           cfg_next = cfg_reg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_delay_ms   <= PRESS_DELAY_RST;
            cfg_reg.release_delay_ms <= RELEASE_DELAY_RST;
            cfg_reg.eager_mode       <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/ikd_integ.sv
// Integrator state (key level and counter) with its per-sample update.
module ikd_integ #(
    parameter int COUNT_MAX = ikd_pkg::COUNT_MAX_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       raw_active,
    input  logic [ikd_pkg::TICK_W-1:0] elapsed_ticks,
    input  ikd_pkg::ikd_cfg_t          cfg,
    output ikd_pkg::ikd_result_t       res
);
    import ikd_pkg::*;

    localparam int CW = $clog2(COUNT_MAX + 1);
    // working width: holds count + ticks and the sum of both delays
    localparam int WW = ((CW > DELAY_W + 1) ? CW : DELAY_W + 1) + 1;
    localparam logic [WW-1:0] MAX_W = WW'(COUNT_MAX);

    logic          key_pressed_reg, key_pressed_next;
    logic [CW-1:0] count_reg, count_next;

    logic          mismatch;
    logic [WW-1:0] count_w, dt_w, dec_w, sum_w, inc_w;
    logic [WW-1:0] limit_w, load_w, load_clamp_w;
    logic          flip;

    always_comb begin
        mismatch = raw_active != key_pressed_reg;
        count_w  = WW'(count_reg);
        dt_w     = WW'(elapsed_ticks);
        dec_w    = (count_w < dt_w) ? '0 : count_w - dt_w;
        sum_w    = count_w + dt_w;
        inc_w    = (sum_w > MAX_W) ? MAX_W : sum_w;

        if (cfg.eager_mode)
            limit_w = WW'(cfg.press_delay_ms) + WW'(cfg.release_delay_ms);
        else if (key_pressed_reg)
            limit_w = WW'(cfg.release_delay_ms);
        else
            limit_w = WW'(cfg.press_delay_ms);

        // eager flip loads the delay of the opposite transition
        load_w       = key_pressed_reg ? WW'(cfg.press_delay_ms) : WW'(cfg.release_delay_ms);
        load_clamp_w = (load_w > MAX_W) ? MAX_W : load_w;

        flip       = 1'b0;
        count_next = count_reg;
        if (!mismatch) begin
            count_next = dec_w[CW-1:0];
        end else if (cfg.eager_mode && count_reg == '0) begin
            count_next = load_clamp_w[CW-1:0];
            flip       = 1'b1;
        end else if (count_w < limit_w) begin
            count_next = inc_w[CW-1:0];
        end else begin
            count_next = '0;
            flip       = 1'b1;
        end
        key_pressed_next = key_pressed_reg ^ flip;

        res.debounced_pressed = key_pressed_next;
        res.state_changed     = flip;
        res.still_active      = key_pressed_next || (count_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pressed_reg <= 1'b0;
            count_reg       <= '0;
        end else if (en) begin
            key_pressed_reg <= key_pressed_next;
            count_reg       <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(count_reg) <= MAX_W)
        else $error("integrator count above maximum");

    a_flip_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        en && res.state_changed |=> key_pressed_reg != $past(key_pressed_reg))
        else $error("state change flagged but key level did not toggle");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(key_pressed_reg) && $stable(count_reg))
        else $error("integrator state moved without a sample");

    a_match_decays: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !mismatch |=> count_reg <= $past(count_reg) && $stable(key_pressed_reg))
        else $error("matching sample raised count or flipped state");

endmodule

### src/integrator_key_debouncer.sv
// Top level of the integrator key debouncer: input register, integrator, result register.
//
//  channel | ports                   | direction | payload
//  --------+-------------------------+-----------+---------------------------------------
//  sample  | s_tvalid/s_tready/s_tdata | in      | [0] raw_active, [10:1] elapsed_ticks
//  result  | m_tvalid/m_tready/m_tdata | out     | [0] debounced_pressed, [1] state_changed,
//          |                         |           | [2] still_active
//  config  | cfg_valid/cfg_ready     | in        | cfg_index, cfg_data (always ready)
//
//  One sample per cycle sustained while m_tready is high; each passes the input register,
//  then the result register. The integrator update (one add or subtract, a clamp and a
//  compare) sits between those two registers; its state is written as the result is captured.
//  Reset (aresetn low, synchronous) empties both registers, releases the key, clears the
//  counter and loads press/release delays of 5 ms and defer mode.
//  When m_tready is low a full result register holds, the input register fills once,
//  and s_tready then drops until the result is taken.
module integrator_key_debouncer #(
    parameter int COUNT_MAX = ikd_pkg::COUNT_MAX_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ikd_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] raw_active, [10:1] elapsed_ticks
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ikd_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] debounced_pressed,
                                                       // [1] state_changed, [2] still_active
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ikd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ikd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ikd_pkg::*;

    ikd_cfg_t    cfg;
    ikd_result_t res;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              raw_reg;
    logic [TICK_W-1:0] ticks_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    ikd_result_t       out_reg;

    logic advance;   // result register free to take a new value
    logic fire;      // item in the input register is processed this cycle
    logic s_xfer;

    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            raw_reg   <= s_tdata[0];
            ticks_reg <= s_tdata[TICK_W:1];
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    ikd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ikd_integ #(
        .COUNT_MAX (COUNT_MAX)
    ) u_integ (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (fire),
        .raw_active    (raw_reg),
        .elapsed_ticks (ticks_reg),
        .cfg           (cfg),
        .res           (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3){1'b0}},
                       out_reg.still_active,
                       out_reg.state_changed,
                       out_reg.debounced_pressed};

endmodule

### tb/sv/tb_integrator_key_debouncer.sv
// Self-checking testbench for integrator_key_debouncer: directed table, random key bounce, scoreboard.
module tb_integrator_key_debouncer;
    import ikd_pkg::*;

    localparam int CNT_MAX      = COUNT_MAX_DEFAULT;
    localparam int TICK_MAX     = (1 << TICK_W) - 1;
    localparam int DELAY_MAX    = (1 << DELAY_W) - 1;
    // Index with no register behind it; the block must drop such writes.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 300;      // long m_tready hold-off to back up the pipe
    localparam int TAIL_CYCLES  = 8;        // settle time after the final drain
    localparam int TIMEOUT      = 2_000_000;
    localparam int DIR_ROWS     = 24;

    typedef enum logic { ROW_SAMPLE, ROW_REG } row_kind_t;

    // One line of the directed table: either a register write or a sample. For samples,
    // 'known' marks rows whose result is typed in; the rest go through the predictor.
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    raw;
        logic [TICK_W-1:0]       ticks;
        logic                    known;
        logic                    exp_pressed;
        logic                    exp_changed;
        logic                    exp_active;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;     // [0] raw_active, [10:1] elapsed_ticks
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // [0] debounced_pressed, [1] state_changed,
                                                // [2] still_active
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers, key state and integrator
    // ------------------------------------------------------------------
    ikd_cfg_t       shadow_cfg;
    logic           key_down;
    int             integ_ms;
    ikd_result_t    key_result_q[$];    // expected results, oldest first
    int             fail_count = 0;
    int             burst_left = 0;
    bit             hold_req   = 1'b0;
    dir_row_t       dir_rows [DIR_ROWS];

    integrator_key_debouncer #(
        .COUNT_MAX (CNT_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int clamp_ms(int v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    // Advance the debouncer by one sample and return the result it must produce.
    function automatic ikd_result_t debounce_sample(logic raw, logic [TICK_W-1:0] ticks);
        ikd_result_t r;
        int          dt;
        int          thresh;
        logic        flip;
        dt   = ticks;
        flip = 1'b0;
        if (raw == key_down) begin
            // level agrees with debounced state: bleed the integrator toward zero
            integ_ms = (integ_ms < dt) ? 0 : integ_ms - dt;
        end else begin
            if (shadow_cfg.eager_mode) begin
                thresh = shadow_cfg.press_delay_ms;
                thresh += shadow_cfg.release_delay_ms;
            end else begin
                thresh = key_down ? shadow_cfg.release_delay_ms : shadow_cfg.press_delay_ms;
            end
            if (shadow_cfg.eager_mode && integ_ms == 0) begin
                // eager flip: load the opposite delay as the verify window
                integ_ms = clamp_ms(key_down ? shadow_cfg.press_delay_ms
                                             : shadow_cfg.release_delay_ms);
                flip = 1'b1;
            end else if (integ_ms < thresh) begin
                integ_ms = clamp_ms(integ_ms + dt);
            end else begin
                integ_ms = 0;
                flip = 1'b1;
            end
            if (flip) begin
                key_down = ~key_down;
            end
        end
        r.debounced_pressed = key_down;
        r.state_changed     = flip;
        r.still_active      = key_down || (integ_ms != 0);
        return r;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PRESS_DELAY:   shadow_cfg.press_delay_ms   = data;
            REG_RELEASE_DELAY: shadow_cfg.release_delay_ms = data;
            REG_EAGER_MODE:    shadow_cfg.eager_mode       = data[0];
            default: ;  // unmapped index: dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Table and random helpers
    // ------------------------------------------------------------------
    function automatic dir_row_t sample_row(logic raw, int ticks);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.raw   = raw;
        row.ticks = TICK_W'(ticks);
        return row;
    endfunction

    function automatic dir_row_t known_row(logic raw, int ticks, logic p, logic c, logic a);
        dir_row_t row;
        row             = sample_row(raw, ticks);
        row.known       = 1'b1;
        row.exp_pressed = p;
        row.exp_changed = c;
        row.exp_active  = a;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = CFG_DATA_W'(data);
        return row;
    endfunction

    // Mostly short debounce windows so flips happen often; now and then an extreme.
    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DELAY_W'(DELAY_MAX);
            2:       return DELAY_W'($urandom_range(0, DELAY_MAX));
            default: return DELAY_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Ticks sized to the current windows, with the odd full-range value.
    function automatic logic [TICK_W-1:0] pick_ticks(int cap);
        if ($urandom_range(0, 15) == 0) begin
            return TICK_W'($urandom_range(0, TICK_MAX));
        end
        return TICK_W'($urandom_range(0, cap));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Leaves cfg_valid high so back-to-back writes do not toggle it in one step;
    // the next sample push lowers it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg_write(idx, data);
    endtask

    // Registers change only with the block empty: stop offering and wait for
    // every outstanding result to come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (key_result_q.size() != 0) @(posedge aclk);
    endtask

    // Offer one sample; the sender runs in bursts with random gaps in between.
    task automatic push_sample(logic raw, logic [TICK_W-1:0] ticks, logic known,
                               ikd_result_t known_res);
        ikd_result_t pred;
        int          gap;
        if (cfg_valid) begin
            cfg_valid <= 1'b0;
        end
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                5:       gap = $urandom_range(5, 30);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({ticks, raw});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transfer taken at this edge: advance the predictor
        pred = debounce_sample(raw, ticks);
        key_result_q.push_back(known ? known_res : pred);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ikd_result_t got;
        ikd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2:0];
            if (key_result_q.size() == 0) begin
                $error("unexpected result transfer, m_tdata=%0h", m_tdata);
                fail_count++;
            end else begin
                want = key_result_q.pop_front();
                if (got.debounced_pressed !== want.debounced_pressed) begin
                    $error("debounced_pressed: expected %0b, got %0b",
                           want.debounced_pressed, got.debounced_pressed);
                    fail_count++;
                end
                if (got.state_changed !== want.state_changed) begin
                    $error("state_changed: expected %0b, got %0b",
                           want.state_changed, got.state_changed);
                    fail_count++;
                end
                if (got.still_active !== want.still_active) begin
                    $error("still_active: expected %0b, got %0b",
                           want.still_active, got.still_active);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls in segments of its own pattern; on request it holds off
    // for a long stretch so the block backs up and drops s_tready.
    // ------------------------------------------------------------------
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                0:       m_tready <= 1'b1;                         // no stalls
                1:       m_tready <= ($urandom_range(0, 3) != 0);  // light stalls
                2:       m_tready <= ($urandom_range(0, 3) == 0);  // heavy stalls
                default: m_tready <= (seg_left % 3 == 0);          // periodic
            endcase
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        ikd_result_t          fixed_res;
        logic [DELAY_W-1:0]   press_ms;
        logic [DELAY_W-1:0]   release_ms;
        logic [CFG_DATA_W-1:0] mode_word;
        logic                 eager;
        logic                 level;
        int                   tick_cap;
        int                   sent;
        int                   n;

        shadow_cfg.press_delay_ms   = PRESS_DELAY_RST;
        shadow_cfg.release_delay_ms = RELEASE_DELAY_RST;
        shadow_cfg.eager_mode       = 1'b0;
        key_down = 1'b0;
        integ_ms = 0;
        level    = 1'b0;

        // Directed table. Starts on reset values (5 ms / 5 ms, defer mode).
        dir_rows = '{
            known_row(1'b0, 0,        1'b0, 1'b0, 1'b0),  // idle after reset
            known_row(1'b1, TICK_MAX, 1'b0, 1'b0, 1'b1),  // max ticks, below window yet
            known_row(1'b1, 0,        1'b1, 1'b1, 1'b1),  // window met: press accepted
            known_row(1'b1, TICK_MAX, 1'b1, 1'b0, 1'b1),  // steady press
            sample_row(1'b0, 3),                          // bounce toward release
            sample_row(1'b1, 1),
            sample_row(1'b0, 10),
            sample_row(1'b0, 0),                          // release accepted
            reg_row(REG_PRESS_DELAY, 0),
            reg_row(REG_RELEASE_DELAY, DELAY_MAX),
            sample_row(1'b1, 0),                          // zero delay: flips at once
            sample_row(1'b0, TICK_MAX),
            reg_row(REG_EAGER_MODE, 1),
            reg_row(REG_SPARE, DELAY_MAX),                // unmapped index, ignored
            sample_row(1'b1, TICK_MAX),
            sample_row(1'b0, 5),                          // eager, zero opposite delay
            sample_row(1'b1, 9),                          // eager, loads the maximum delay
            sample_row(1'b0, TICK_MAX),                   // verify window met
            reg_row(REG_PRESS_DELAY, DELAY_MAX),
            sample_row(1'b1, 0),
            sample_row(1'b0, 0),                          // sum of delays above counter max:
            sample_row(1'b0, TICK_MAX),                   // saturates, never flips
            sample_row(1'b1, TICK_MAX),
            reg_row(REG_EAGER_MODE, 0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                fixed_res.debounced_pressed = dir_rows[i].exp_pressed;
                fixed_res.state_changed     = dir_rows[i].exp_changed;
                fixed_res.still_active      = dir_rows[i].exp_active;
                push_sample(dir_rows[i].raw, dir_rows[i].ticks, dir_rows[i].known, fixed_res);
            end
        end

        // Random phases: each one reprograms all registers, then plays key
        // presses and releases with contact bounce, plus some pure noise.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            if (phase == 0) begin
                press_ms   = DELAY_W'(DELAY_MAX);
                release_ms = '0;
                eager      = 1'b1;
            end else if (phase == 1) begin
                press_ms   = '0;
                release_ms = DELAY_W'(DELAY_MAX);
                eager      = 1'b0;
            end else begin
                press_ms   = pick_delay();
                release_ms = pick_delay();
                eager      = 1'($urandom_range(0, 1));
            end
            // upper bits of the mode word are don't-care; exercise them anyway
            mode_word    = CFG_DATA_W'($urandom);
            mode_word[0] = eager;
            write_reg(REG_PRESS_DELAY, press_ms);
            write_reg(REG_RELEASE_DELAY, release_ms);
            write_reg(REG_EAGER_MODE, mode_word);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            end

            tick_cap = (int'(press_ms) + int'(release_ms)) / 6 + 2;
            if (tick_cap > TICK_MAX) begin
                tick_cap = TICK_MAX;
            end
            if (phase == 0 || phase == RAND_PHASES / 2) begin
                hold_req = 1'b1;
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    // noise: random levels and any tick count
                    n = $urandom_range(1, 5);
                    repeat (n) begin
                        push_sample(1'($urandom), TICK_W'($urandom), 1'b0, fixed_res);
                    end
                    sent += n;
                end else begin
                    // key edge: short bounce, then the new level held for a while
                    level = ~level;
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        push_sample(1'($urandom), TICK_W'($urandom_range(0, 2)), 1'b0,
                                    fixed_res);
                    end
                    sent += n;
                    n = $urandom_range(1, 16);
                    repeat (n) begin
                        push_sample(level, pick_ticks(tick_cap), 1'b0, fixed_res);
                    end
                    sent += n;
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_integrator_key_debouncer: PASS");
        end else begin
            $display("tb_integrator_key_debouncer: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(TIMEOUT);
        $display("tb_integrator_key_debouncer: FAIL");
        $finish;
    end

endmodule
